// ----- sv/stz_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the symmetric Toeplitz solver.
// No dependencies; used by stz_mul, stz_div and the top level.
package stz_pkg;

   localparam int MAX_ORDER_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS      = 16;
   localparam int FIELD_WIDTH    = 32;
   localparam int INDEX_WIDTH    = 6;
   localparam int ORDER_WIDTH    = 7;

   typedef enum logic [14:0] {
      ST_LOAD  = 15'b000000000000001,
      ST_DIV0  = 15'b000000000000010,
      ST_DIV1  = 15'b000000000000100,
      ST_FETCH = 15'b000000000001000,
      ST_TGT   = 15'b000000000010000,
      ST_OPRD  = 15'b000000000100000,
      ST_OPMUL = 15'b000000001000000,
      ST_DIVX  = 15'b000000010000000,
      ST_DIVG  = 15'b000000100000000,
      ST_DIVH  = 15'b000001000000000,
      ST_UPD0  = 15'b000010000000000,
      ST_ORD   = 15'b000100000000000,
      ST_OPUT  = 15'b001000000000000,
      ST_FAIL  = 15'b010000000000000,
      ST_SPARE = 15'b100000000000000
   } state_type;

   // micro-operations of the recursion, one multiply each
   typedef enum logic [3:0] {
      OP_NX = 4'd0,
      OP_NG = 4'd1,
      OP_UX = 4'd2,
      OP_GN = 4'd3,
      OP_GD = 4'd4,
      OP_HN = 4'd5,
      OP_HD = 4'd6,
      OP_UG = 4'd7,
      OP_UH = 4'd8
   } op_type;

endpackage

// ----- sv/symmetric_toeplitz_solver.sv -----
`timescale 1ns / 1ps
// Top level of the Levinson-recursion solver for symmetric Toeplitz systems.
// Depends on stz_pkg, stz_mul and stz_div.
//
// Usage:
//  - Write csr_write_data (order, 1..MAX_ORDER; 0 acts as 1, larger values
//    as MAX_ORDER) with csr_write_enable while idle; this also restarts loading.
//  - Send 'order' req_ transactions, each one first-row coefficient r[i] and
//    one right-hand value y[i] in Q16.16. req_ready is high only while loading.
//  - The transaction completing a system starts the solve; afterwards the
//    block sends x[0..order-1] on rsp_ in index order, rsp_last on the final
//    one. A zero pivot yields one transaction with rsp_singular and rsp_last.
//  - Work: one multiplier is shared by every product of the recursion; there
//    are about 4.5*order^2 of them, plus 3*order-3 divisions (one at order
//    one) in the serial divider. Loading accepts one transaction per cycle.
//  - A stalled receiver holds the current result in the output register; the
//    block reads the next one and waits with it, and after the last result is
//    registered it already accepts the next system.
//  - Reset clears order to 1, the load count and the handshakes; the stores
//    hold nothing until written.
module symmetric_toeplitz_solver #(
   parameter int MAX_ORDER  = stz_pkg::MAX_ORDER_DEF,
   parameter int DATA_WIDTH = stz_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [stz_pkg::FIELD_WIDTH-1:0] req_row_coeff,
   input  logic signed [stz_pkg::FIELD_WIDTH-1:0] req_rhs_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [stz_pkg::FIELD_WIDTH-1:0] rsp_solution_value,
   output logic [stz_pkg::INDEX_WIDTH-1:0]        rsp_solution_index,
   output logic                                   rsp_singular,
   output logic                                   rsp_last,
   input  logic                                   csr_write_enable,
   input  logic [stz_pkg::ORDER_WIDTH-1:0]        csr_write_data
);
   localparam int DW  = DATA_WIDTH;
   localparam int FW  = stz_pkg::FIELD_WIDTH;
   localparam int XW  = stz_pkg::INDEX_WIDTH;
   localparam int OW  = stz_pkg::ORDER_WIDTH;
   localparam int IW  = $clog2(MAX_ORDER);
   localparam int NW  = $clog2(MAX_ORDER + 1);
   localparam int GAW = $clog2(2 * MAX_ORDER);
   localparam int AW  = DW + IW + 1;
   localparam int EW  = (DW > FW) ? DW : FW;

   // stores: r, y/x, and two banks each of forward and backward vectors
   logic signed [DW-1:0] r_mem [MAX_ORDER];
   logic signed [DW-1:0] x_mem [MAX_ORDER];
   logic signed [DW-1:0] g_mem [2*MAX_ORDER];
   logic signed [DW-1:0] h_mem [2*MAX_ORDER];

   stz_pkg::state_type state_ff, state_in;
   stz_pkg::op_type    op_ff, op_in;
   logic [OW-1:0]      order_ff, order_in;
   logic [IW-1:0]      lc_ff, lc_in, j_ff, j_in, k_ff, k_in;
   logic [NW-1:0]      m_ff, m_in;
   logic               bsel_ff, bsel_in;
   logic               mul_run_ff, mul_run_in, div_run_ff, div_run_in;
   logic signed [DW-1:0] r0_ff, r0_in, y0_ff, y0_in, r1_ff, r1_in;
   logic signed [DW-1:0] tx_ff, tx_in, tr_ff, tr_in;
   logic signed [DW-1:0] xm_ff, xm_in, gm_ff, gm_in, hm_ff, hm_in;
   logic signed [AW-1:0] acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic signed [AW-1:0] acc2_ff, acc2_in, acc3_ff, acc3_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0] rsp_value_ff, rsp_value_in;
   logic [XW-1:0]        rsp_index_ff, rsp_index_in;
   logic                 rsp_singular_ff, rsp_singular_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 r_we, x_we, g_we, h_we, rd_en;
   logic [IW-1:0]        r_wa, x_wa, r_ra, x_ra;
   logic [GAW-1:0]       g_wa, h_wa, g_ra, h_ra;
   logic signed [DW-1:0] r_wd, x_wd, g_wd, h_wd;
   logic signed [DW-1:0] r_rd_ff, x_rd_ff, g_rd_ff, h_rd_ff;

   logic                 mul_start, mul_done, div_start, div_done;
   logic signed [DW-1:0] mul_a, mul_b, mul_p, div_num, div_den, div_q;

   logic [NW-1:0]        n_eff, m1;
   logic [IW-1:0]        m_idx, mj, mj1;
   logic                 more_g, j_last, slot_free;
   logic signed [DW-1:0] c_sel, diff, in_r, in_y;
   stz_pkg::state_type   nm_state;

   function automatic logic signed [DW-1:0] sat_acc(input logic signed [AW-1:0] v);
      if (&v[AW-1:DW-1] || ~|v[AW-1:DW-1])
         sat_acc = v[DW-1:0];
      else
         sat_acc = {v[AW-1], {(DW-1){~v[AW-1]}}};
   endfunction

   function automatic logic signed [DW-1:0] sat_in(input logic signed [FW-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      if (&e[EW-1:DW-1] || ~|e[EW-1:DW-1])
         sat_in = e[DW-1:0];
      else
         sat_in = {e[EW-1], {(DW-1){~e[EW-1]}}};
   endfunction

   function automatic logic [GAW-1:0] gaddr(input logic bank, input logic [IW-1:0] idx);
      gaddr = GAW'(idx) + (bank ? GAW'(MAX_ORDER) : GAW'(0));
   endfunction

   stz_mul #(.DW(DW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   stz_div #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .q     (div_q)
   );

   // effective order and loop bookkeeping
   always_comb begin
      if (order_ff == '0)
         n_eff = NW'(1);
      else if (order_ff > OW'(MAX_ORDER))
         n_eff = NW'(MAX_ORDER);
      else
         n_eff = NW'(order_ff);
      m_idx     = m_ff[IW-1:0];
      m1        = m_ff + NW'(1);
      mj        = m_idx - j_ff;
      mj1       = mj - IW'(1);
      more_g    = m1 < n_eff;
      j_last    = (NW'(j_ff) + NW'(1)) == m_ff;
      slot_free = !rsp_valid_ff || rsp_ready;
      nm_state  = (m1 == n_eff) ? stz_pkg::ST_ORD : stz_pkg::ST_FETCH;
      in_r      = sat_in(req_row_coeff);
      in_y      = sat_in(req_rhs_value);
   end

   // operand routing of the current micro-operation
   always_comb begin
      r_ra  = '0;
      x_ra  = '0;
      g_ra  = '0;
      h_ra  = '0;
      mul_a = g_rd_ff;
      mul_b = r_rd_ff;
      c_sel = x_rd_ff;
      unique case (op_ff)
         stz_pkg::OP_NX: begin
            r_ra  = mj;
            x_ra  = j_ff;
            mul_a = x_rd_ff;
         end
         stz_pkg::OP_NG, stz_pkg::OP_HD: begin
            r_ra = mj;
            g_ra = gaddr(bsel_ff, mj1);
         end
         stz_pkg::OP_UX: begin
            g_ra  = gaddr(bsel_ff, j_ff);
            x_ra  = mj1;
            mul_a = xm_ff;
            mul_b = g_rd_ff;
         end
         stz_pkg::OP_GN: begin
            r_ra = mj;
            g_ra = gaddr(bsel_ff, j_ff);
         end
         stz_pkg::OP_GD: begin
            r_ra  = mj;
            h_ra  = gaddr(bsel_ff, mj1);
            mul_a = h_rd_ff;
         end
         stz_pkg::OP_HN: begin
            r_ra  = mj;
            h_ra  = gaddr(bsel_ff, j_ff);
            mul_a = h_rd_ff;
         end
         stz_pkg::OP_UG: begin
            h_ra  = gaddr(bsel_ff, mj1);
            g_ra  = gaddr(bsel_ff, j_ff);
            mul_a = gm_ff;
            mul_b = h_rd_ff;
            c_sel = g_rd_ff;
         end
         stz_pkg::OP_UH: begin
            g_ra  = gaddr(bsel_ff, j_ff);
            h_ra  = gaddr(bsel_ff, mj1);
            mul_a = hm_ff;
            mul_b = g_rd_ff;
            c_sel = h_rd_ff;
         end
         default: begin
            r_ra = '0;
         end
      endcase
      // fetch reuses the x and r read ports, the output phase the x read port
      if (state_ff == stz_pkg::ST_FETCH) begin
         x_ra = m_idx;
         r_ra = more_g ? m1[IW-1:0] : '0;
      end else if (state_ff == stz_pkg::ST_ORD) begin
         x_ra = k_ff;
      end
      diff = sat_acc(AW'(c_sel) - AW'(mul_p));
   end

   // divider operands per division state
   always_comb begin
      div_num = y0_ff;
      div_den = r0_ff;
      unique case (state_ff)
         stz_pkg::ST_DIV1: div_num = r1_ff;
         stz_pkg::ST_DIVX: begin
            div_num = sat_acc(acc0_ff - AW'(tx_ff));
            div_den = sat_acc(acc1_ff - AW'(r0_ff));
         end
         stz_pkg::ST_DIVG: begin
            div_num = sat_acc(acc0_ff - AW'(tr_ff));
            div_den = sat_acc(acc1_ff - AW'(r0_ff));
         end
         stz_pkg::ST_DIVH: begin
            div_num = sat_acc(acc2_ff - AW'(tr_ff));
            div_den = sat_acc(acc3_ff - AW'(r0_ff));
         end
         default: div_num = y0_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      order_in        = order_ff;
      lc_in           = lc_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      m_in            = m_ff;
      bsel_in         = bsel_ff;
      mul_run_in      = mul_run_ff;
      div_run_in      = div_run_ff;
      r0_in           = r0_ff;
      y0_in           = y0_ff;
      r1_in           = r1_ff;
      tx_in           = tx_ff;
      tr_in           = tr_ff;
      xm_in           = xm_ff;
      gm_in           = gm_ff;
      hm_in           = hm_ff;
      acc0_in         = acc0_ff;
      acc1_in         = acc1_ff;
      acc2_in         = acc2_ff;
      acc3_in         = acc3_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_singular_in = rsp_singular_ff;
      rsp_last_in     = rsp_last_ff;
      r_we            = 1'b0;
      r_wa            = lc_ff;
      r_wd            = in_r;
      x_we            = 1'b0;
      x_wa            = lc_ff;
      x_wd            = in_y;
      g_we            = 1'b0;
      g_wa            = '0;
      g_wd            = div_q;
      h_we            = 1'b0;
      h_wa            = '0;
      h_wd            = div_q;
      rd_en           = 1'b0;
      mul_start       = 1'b0;
      div_start       = 1'b0;

      unique case (state_ff)
         stz_pkg::ST_LOAD: begin
            if (req_valid) begin
               r_we = 1'b1;
               x_we = 1'b1;
               if (lc_ff == '0) begin
                  r0_in = in_r;
                  y0_in = in_y;
               end
               if (lc_ff == IW'(1))
                  r1_in = in_r;
               if ((NW'(lc_ff) + NW'(1)) == n_eff) begin
                  lc_in      = '0;
                  div_run_in = 1'b0;
                  state_in   = stz_pkg::ST_DIV0;
               end else begin
                  lc_in = lc_ff + IW'(1);
               end
            end
         end
         stz_pkg::ST_DIV0: begin
            if (!div_run_ff) begin
               if (r0_ff == '0) begin
                  state_in = stz_pkg::ST_FAIL;
               end else begin
                  div_start  = 1'b1;
                  div_run_in = 1'b1;
               end
            end else if (div_done) begin
               div_run_in = 1'b0;
               x_we       = 1'b1;
               x_wa       = '0;
               x_wd       = div_q;
               bsel_in    = 1'b0;
               k_in       = '0;
               state_in   = (n_eff > NW'(1)) ? stz_pkg::ST_DIV1 : stz_pkg::ST_ORD;
            end
         end
         stz_pkg::ST_DIV1: begin
            if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               div_run_in = 1'b0;
               g_we       = 1'b1;
               h_we       = 1'b1;
               m_in       = NW'(1);
               state_in   = stz_pkg::ST_FETCH;
            end
         end
         stz_pkg::ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = stz_pkg::ST_TGT;
         end
         stz_pkg::ST_TGT: begin
            tx_in    = x_rd_ff;
            tr_in    = r_rd_ff;
            acc0_in  = '0;
            acc1_in  = '0;
            j_in     = '0;
            op_in    = stz_pkg::OP_NX;
            state_in = stz_pkg::ST_OPRD;
         end
         stz_pkg::ST_OPRD: begin
            rd_en    = 1'b1;
            state_in = stz_pkg::ST_OPMUL;
         end
         stz_pkg::ST_OPMUL: begin
            if (!mul_run_ff) begin
               mul_start  = 1'b1;
               mul_run_in = 1'b1;
            end else if (mul_done) begin
               mul_run_in = 1'b0;
               state_in   = stz_pkg::ST_OPRD;
               unique case (op_ff)
                  stz_pkg::OP_NX: begin
                     acc0_in = acc0_ff + AW'(mul_p);
                     op_in   = stz_pkg::OP_NG;
                  end
                  stz_pkg::OP_NG: begin
                     acc1_in = acc1_ff + AW'(mul_p);
                     if (j_last) begin
                        div_run_in = 1'b0;
                        state_in   = stz_pkg::ST_DIVX;
                     end else begin
                        j_in  = j_ff + IW'(1);
                        op_in = stz_pkg::OP_NX;
                     end
                  end
                  stz_pkg::OP_UX: begin
                     x_we = 1'b1;
                     x_wa = mj1;
                     x_wd = diff;
                     if (j_last) begin
                        j_in = '0;
                        if (more_g) begin
                           acc0_in = '0;
                           acc1_in = '0;
                           acc2_in = '0;
                           acc3_in = '0;
                           op_in   = stz_pkg::OP_GN;
                        end else begin
                           m_in     = m1;
                           k_in     = '0;
                           state_in = nm_state;
                        end
                     end else begin
                        j_in = j_ff + IW'(1);
                     end
                  end
                  stz_pkg::OP_GN: begin
                     acc0_in = acc0_ff + AW'(mul_p);
                     op_in   = stz_pkg::OP_GD;
                  end
                  stz_pkg::OP_GD: begin
                     acc1_in = acc1_ff + AW'(mul_p);
                     op_in   = stz_pkg::OP_HN;
                  end
                  stz_pkg::OP_HN: begin
                     acc2_in = acc2_ff + AW'(mul_p);
                     op_in   = stz_pkg::OP_HD;
                  end
                  stz_pkg::OP_HD: begin
                     acc3_in = acc3_ff + AW'(mul_p);
                     if (j_last) begin
                        div_run_in = 1'b0;
                        state_in   = stz_pkg::ST_DIVG;
                     end else begin
                        j_in  = j_ff + IW'(1);
                        op_in = stz_pkg::OP_GN;
                     end
                  end
                  stz_pkg::OP_UG: begin
                     g_we  = 1'b1;
                     g_wa  = gaddr(~bsel_ff, j_ff);
                     g_wd  = diff;
                     op_in = stz_pkg::OP_UH;
                  end
                  stz_pkg::OP_UH: begin
                     h_we = 1'b1;
                     h_wa = gaddr(~bsel_ff, mj1);
                     h_wd = diff;
                     if (j_last) begin
                        // new bank becomes current
                        bsel_in  = ~bsel_ff;
                        j_in     = '0;
                        m_in     = m1;
                        k_in     = '0;
                        state_in = nm_state;
                     end else begin
                        j_in  = j_ff + IW'(1);
                        op_in = stz_pkg::OP_UG;
                     end
                  end
                  default: state_in = stz_pkg::ST_OPRD;
               endcase
            end
         end
         stz_pkg::ST_DIVX, stz_pkg::ST_DIVG, stz_pkg::ST_DIVH: begin
            if (!div_run_ff) begin
               if (div_den == '0) begin
                  state_in = stz_pkg::ST_FAIL;
               end else begin
                  div_start  = 1'b1;
                  div_run_in = 1'b1;
               end
            end else if (div_done) begin
               div_run_in = 1'b0;
               if (state_ff == stz_pkg::ST_DIVX) begin
                  x_we     = 1'b1;
                  x_wa     = m_idx;
                  x_wd     = div_q;
                  xm_in    = div_q;
                  j_in     = '0;
                  op_in    = stz_pkg::OP_UX;
                  state_in = stz_pkg::ST_OPRD;
               end else if (state_ff == stz_pkg::ST_DIVG) begin
                  gm_in    = div_q;
                  state_in = stz_pkg::ST_DIVH;
               end else begin
                  hm_in    = div_q;
                  state_in = stz_pkg::ST_UPD0;
               end
            end
         end
         stz_pkg::ST_UPD0: begin
            g_we     = 1'b1;
            g_wa     = gaddr(~bsel_ff, m_idx);
            g_wd     = gm_ff;
            h_we     = 1'b1;
            h_wa     = gaddr(~bsel_ff, m_idx);
            h_wd     = hm_ff;
            j_in     = '0;
            op_in    = stz_pkg::OP_UG;
            state_in = stz_pkg::ST_OPRD;
         end
         stz_pkg::ST_ORD: begin
            rd_en    = 1'b1;
            state_in = stz_pkg::ST_OPUT;
         end
         stz_pkg::ST_OPUT: begin
            // hold until the output register frees up
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = FW'(x_rd_ff);
               rsp_index_in    = XW'(k_ff);
               rsp_singular_in = 1'b0;
               rsp_last_in     = (NW'(k_ff) + NW'(1)) == n_eff;
               if ((NW'(k_ff) + NW'(1)) == n_eff) begin
                  state_in = stz_pkg::ST_LOAD;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = stz_pkg::ST_ORD;
               end
            end
         end
         stz_pkg::ST_FAIL: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = '0;
               rsp_index_in    = '0;
               rsp_singular_in = 1'b1;
               rsp_last_in     = 1'b1;
               div_run_in      = 1'b0;
               state_in        = stz_pkg::ST_LOAD;
            end
         end
         default: state_in = stz_pkg::ST_LOAD;
      endcase

      if (csr_write_enable) begin
         order_in = csr_write_data;
         lc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stz_pkg::ST_LOAD;
         order_ff     <= OW'(1);
         lc_ff        <= '0;
         bsel_ff      <= 1'b0;
         mul_run_ff   <= 1'b0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         lc_ff        <= lc_in;
         bsel_ff      <= bsel_in;
         mul_run_ff   <= mul_run_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      j_ff            <= j_in;
      k_ff            <= k_in;
      m_ff            <= m_in;
      r0_ff           <= r0_in;
      y0_ff           <= y0_in;
      r1_ff           <= r1_in;
      tx_ff           <= tx_in;
      tr_ff           <= tr_in;
      xm_ff           <= xm_in;
      gm_ff           <= gm_in;
      hm_ff           <= hm_in;
      acc0_ff         <= acc0_in;
      acc1_ff         <= acc1_in;
      acc2_ff         <= acc2_in;
      acc3_ff         <= acc3_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_singular_ff <= rsp_singular_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // memories: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (r_we)
         r_mem[r_wa] <= r_wd;
      if (rd_en)
         r_rd_ff <= r_mem[r_ra];
   end

   always_ff @(posedge clock) begin
      if (x_we)
         x_mem[x_wa] <= x_wd;
      if (rd_en)
         x_rd_ff <= x_mem[x_ra];
   end

   always_ff @(posedge clock) begin
      if (g_we)
         g_mem[g_wa] <= g_wd;
      if (rd_en)
         g_rd_ff <= g_mem[g_ra];
   end

   always_ff @(posedge clock) begin
      if (h_we)
         h_mem[h_wa] <= h_wd;
      if (rd_en)
         h_rd_ff <= h_mem[h_ra];
   end

   assign req_ready          = (state_ff == stz_pkg::ST_LOAD);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_value = rsp_value_ff;
   assign rsp_solution_index = rsp_index_ff;
   assign rsp_singular       = rsp_singular_ff;
   assign rsp_last           = rsp_last_ff;
endmodule

// ----- sv/stz_mul.sv -----
`timescale 1ns / 1ps
// Sequential fixed-point multiplier: four half-width partial products,
// then round to nearest (ties away) and saturate. Depends on stz_pkg.
module stz_mul #(
   parameter int DW = stz_pkg::DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] b,
   output logic                 done,
   output logic signed [DW-1:0] p
);
   localparam int HW = (DW + 1) / 2;
   localparam int PW = 4 * HW;
   localparam int FB = stz_pkg::FRAC_BITS;
   localparam int MW = PW - FB + 1;

   logic [2*HW-1:0]    ua_ff, ua_in, ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [PW-1:0]      acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [DW-1:0] p_ff, p_in;

   logic [HW-1:0]      ah, bh;
   logic [2*HW-1:0]    pp;
   logic [PW-1:0]      pp_sh;
   logic [MW-1:0]      mres;
   logic [MW-1:0]      lim_p, lim_n;
   logic [DW-1:0]      ma, mb;

   always_comb begin
      ma     = a[DW-1] ? (~a + 1'b1) : a;
      mb     = b[DW-1] ? (~b + 1'b1) : b;
      ah     = cnt_ff[0] ? ua_ff[2*HW-1:HW] : ua_ff[HW-1:0];
      bh     = cnt_ff[1] ? ub_ff[2*HW-1:HW] : ub_ff[HW-1:0];
      pp     = ah * bh;
      unique case (cnt_ff[1:0])
         2'd0:    pp_sh = PW'(pp);
         2'd3:    pp_sh = PW'(pp) << (2 * HW);
         default: pp_sh = PW'(pp) << HW;
      endcase
      mres   = MW'(acc_ff[PW-1:FB]) + MW'(acc_ff[FB-1]);
      lim_p  = MW'({(DW-1){1'b1}});
      lim_n  = MW'(1) << (DW - 1);

      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      p_in    = p_ff;
      if (start) begin
         ua_in   = (2*HW)'(ma);
         ub_in   = (2*HW)'(mb);
         neg_in  = a[DW-1] ^ b[DW-1];
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 3'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff)
               p_in = (mres > lim_p) ? lim_p[DW-1:0] : mres[DW-1:0];
            else if (mres > lim_n)
               p_in = {1'b1, {(DW-1){1'b0}}};
            else
               p_in = DW'(~mres + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      p_ff   <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff;
endmodule

// ----- sv/stz_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider for (num * 2^FRAC) / den, truncating toward zero
// and saturating. One quotient bit per cycle. Depends on stz_pkg.
module stz_div #(
   parameter int DW = stz_pkg::DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic                 done,
   output logic signed [DW-1:0] q
);
   localparam int QW = DW + stz_pkg::FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0]  dm_ff, dm_in, rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic           neg_ff, neg_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;
   logic signed [DW-1:0] q_ff, q_in;

   logic [DW:0]    t;
   logic           ge;
   logic [DW-1:0]  mn, md;
   logic [QW-1:0]  lim_p, lim_n;

   always_comb begin
      mn    = num[DW-1] ? (~num + 1'b1) : num;
      md    = den[DW-1] ? (~den + 1'b1) : den;
      t     = {rem_ff, quo_ff[QW-1]};
      ge    = t >= {1'b0, dm_ff};
      lim_p = QW'({(DW-1){1'b1}});
      lim_n = QW'(1) << (DW - 1);

      dm_in   = dm_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      if (start) begin
         dm_in   = md;
         rem_in  = '0;
         quo_in  = {mn, {stz_pkg::FRAC_BITS{1'b0}}};
         neg_in  = num[DW-1] ^ den[DW-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != CW'(QW)) begin
            rem_in = ge ? DW'(t - {1'b0, dm_ff}) : t[DW-1:0];
            quo_in = {quo_ff[QW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff)
               q_in = (quo_ff > lim_p) ? lim_p[DW-1:0] : quo_ff[DW-1:0];
            else if (quo_ff > lim_n)
               q_in = {1'b1, {(DW-1){1'b0}}};
            else
               q_in = DW'(~quo_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dm_ff  <= dm_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;
endmodule
